// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// shared types and constants of the palette lookup interpolator
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned PaletteDepthDefault = 256;
  localparam int unsigned FracBitsDefault     = 8;

  localparam int unsigned SmoothW  = 24;
  localparam int unsigned MaxIterW = 16;
  localparam int unsigned PalLenW  = 9;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 4 * ChanW;
  localparam int unsigned ProdW    = SmoothW + PalLenW;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [MaxIterW-1:0] MaxIterReset = 16'd256;
  localparam logic [PalLenW-1:0]  PalLenReset  = 9'd256;
  localparam logic [ChanW-1:0]    InsideAlpha  = 8'hFF;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_WRITE  = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ITER = 1'b0,
    CFG_PAL_LEN  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e             action;
    logic [SmoothW-1:0]  smooth_iter;
    logic [IndexW-1:0]   entry_index;
    logic [ChanW-1:0]    entry_red;
    logic [ChanW-1:0]    entry_green;
    logic [ChanW-1:0]    entry_blue;
    logic [ChanW-1:0]    entry_alpha;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             inside_set;
  } out_item_t;

  // red in the low byte of a palette word
  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } color_t;

  typedef struct packed {
    logic    valid;
    action_e action;
    logic    in_set;
  } ctl_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    color_t            color;
  } wr_t;

endpackage

// ===== rtl/pli_if.sv =====
// ----------------------------------------------------------------------------
// pli_in_if / pli_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface pli_in_if;
  import pli_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pli_out_if;
  import pli_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/palette_lookup_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// palette_lookup_interpolator_core
// maps a smooth iteration value to an RGBA color through a palette RAM
// ----------------------------------------------------------------------------
// an item passes the entry stage, divider stages, RAM read stage and output buffer
// throughput: one item per cycle when not stalled, set by the one-bit-per-stage divider pipe
// the pipe stalls as a whole only when the two-entry output buffer is full
// palette writes travel the pipe and commit in order at the RAM stage
// reset clears control state and config; palette RAM is not cleared
module palette_lookup_interpolator_core #(
  parameter int unsigned PaletteDepth = pli_pkg::PaletteDepthDefault,
  parameter int unsigned FracBits     = pli_pkg::FracBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pli_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pli_pkg::CfgDataW-1:0]  cfg_wdata_i,
  pli_in_if.sink                        in_item_i,
  pli_out_if.source                     out_item_o
);
  import pli_pkg::*;

  localparam int unsigned AddrW = $clog2(PaletteDepth);
  localparam int unsigned QuotW = PalLenW + FracBits;
  localparam int unsigned CmpW  = (MaxIterW + FracBits > SmoothW) ?
                                  MaxIterW + FracBits : SmoothW;
  localparam logic [1:0]  BufFull = 2'd2;

  // config
  logic [MaxIterW-1:0] max_iter_q;
  logic [PalLenW-1:0]  pal_len_q;
  logic [PalLenW-1:0]  len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterReset;
      pal_len_q  <= PalLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[MaxIterW-1:0];
        CFG_PAL_LEN:  pal_len_q  <= cfg_wdata_i[PalLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    len_eff = (pal_len_q == '0) ? PalLenW'(1) : pal_len_q;
    if (32'(len_eff) > PaletteDepth) begin
      len_eff = PalLenW'(PaletteDepth);
    end
  end

  // output buffer state, needed for the pipe enable
  logic      en;
  logic [1:0] cnt_q;

  assign en              = (cnt_q != BufFull);
  assign in_item_i.ready = en;

  // entry stage: inside test and numerator product
  ctl_t                s0_ctl_q;
  logic [ProdW-1:0]    s0_num_q;
  wr_t                 s0_wr_q;
  logic                inside_in;

  assign inside_in = CmpW'(in_item_i.data.smooth_iter) >= (CmpW'(max_iter_q) << FracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else if (en) begin
      s0_ctl_q.valid  <= in_item_i.valid;
      s0_ctl_q.action <= in_item_i.data.action;
      s0_ctl_q.in_set <= inside_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_num_q              <= ProdW'(in_item_i.data.smooth_iter) * ProdW'(len_eff);
      s0_wr_q.index         <= in_item_i.data.entry_index;
      s0_wr_q.color.red     <= in_item_i.data.entry_red;
      s0_wr_q.color.green   <= in_item_i.data.entry_green;
      s0_wr_q.color.blue    <= in_item_i.data.entry_blue;
      s0_wr_q.color.alpha   <= in_item_i.data.entry_alpha;
    end
  end

  // divider
  ctl_t             dv_ctl;
  logic [QuotW-1:0] dv_quot;
  wr_t              dv_wr;

  pli_div_pipe #(
    .QuotW (QuotW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (s0_ctl_q),
    .num_i  (s0_num_q),
    .wr_i   (s0_wr_q),
    .div_i  (max_iter_q),
    .ctl_o  (dv_ctl),
    .quot_o (dv_quot),
    .wr_o   (dv_wr)
  );

  // palette access
  logic [PalLenW-1:0]  whole;
  logic [FracBits-1:0] frac;
  logic [PalLenW:0]    next_idx;
  logic [PalLenW:0]    hi_idx;
  logic [AddrW-1:0]    raddr_a;
  logic [AddrW-1:0]    raddr_b;
  logic                ram_we;
  logic [ColorW-1:0]   rd_lo;
  logic [ColorW-1:0]   rd_hi;

  assign whole    = dv_quot[QuotW-1:FracBits];
  assign frac     = dv_quot[FracBits-1:0];
  assign next_idx = {1'b0, whole} + (PalLenW + 1)'(1);
  assign hi_idx   = (next_idx >= {1'b0, len_eff}) ? '0 : next_idx;
  assign raddr_a  = AddrW'(whole);
  assign raddr_b  = AddrW'(hi_idx);
  assign ram_we   = en && dv_ctl.valid && (dv_ctl.action == ACT_WRITE) &&
                    (32'(dv_wr.index) < PaletteDepth);

  pli_ram #(
    .Width (ColorW),
    .Depth (PaletteDepth)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (AddrW'(dv_wr.index)),
    .wdata_i   (dv_wr.color),
    .re_i      (en),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_lo),
    .rdata_b_o (rd_hi)
  );

  logic                rd_valid_q;
  logic                rd_inside_q;
  logic [FracBits-1:0] rd_frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (en) begin
      rd_valid_q <= dv_ctl.valid && (dv_ctl.action == ACT_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_inside_q <= dv_ctl.in_set;
      rd_frac_q   <= frac;
    end
  end

  // blend
  color_t    mixed;
  out_item_t result;

  pli_blend #(
    .FracBits (FracBits)
  ) u_blend (
    .lo_i    (color_t'(rd_lo)),
    .hi_i    (color_t'(rd_hi)),
    .frac_i  (rd_frac_q),
    .color_o (mixed)
  );

  assign result.red        = rd_inside_q ? '0 : mixed.red;
  assign result.green      = rd_inside_q ? '0 : mixed.green;
  assign result.blue       = rd_inside_q ? '0 : mixed.blue;
  assign result.alpha      = rd_inside_q ? InsideAlpha : mixed.alpha;
  assign result.inside_set = rd_inside_q;

  // two-entry output buffer
  out_item_t buf_q [2];
  logic      wptr_q;
  logic      rptr_q;
  logic      push;
  logic      pop;

  assign push = en && rd_valid_q;
  assign pop  = out_item_o.valid && out_item_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= result;
    end
  end

  assign out_item_o.valid = (cnt_q != '0);
  assign out_item_o.data  = buf_q[rptr_q];

  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_item_o.valid && out_item_o.data.inside_set |->
      (out_item_o.data.red == '0) && (out_item_o.data.green == '0) &&
      (out_item_o.data.blue == '0) && (out_item_o.data.alpha == InsideAlpha))
    else $error("inside result is not opaque black");

  a_buf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output buffer count lost an item");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && rd_valid_q && !rd_inside_q |=> $stable(rd_lo) && $stable(rd_hi))
    else $error("palette read data changed during stall");

endmodule

// ===== rtl/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// generic RAM, one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== rtl/pli_div_pipe.sv =====
// ----------------------------------------------------------------------------
// pli_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module pli_div_pipe #(
  parameter int unsigned QuotW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pli_pkg::ctl_t                 ctl_i,
  input  logic [pli_pkg::ProdW-1:0]     num_i,
  input  pli_pkg::wr_t                  wr_i,
  input  logic [pli_pkg::MaxIterW-1:0]  div_i,
  output pli_pkg::ctl_t                 ctl_o,
  output logic [QuotW-1:0]              quot_o,
  output pli_pkg::wr_t                  wr_o
);
  import pli_pkg::*;

  logic [MaxIterW-1:0] rem_q [QuotW];
  logic [QuotW-1:0]    lo_q  [QuotW];
  ctl_t                ctl_q [QuotW];
  wr_t                 wr_q  [QuotW];

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    logic [MaxIterW-1:0] rem_in;
    logic [QuotW-1:0]    lo_in;
    ctl_t                ctl_in;
    wr_t                 wr_in;
    logic [MaxIterW:0]   trial;
    logic [MaxIterW:0]   diff;
    logic                take;

    if (s == 0) begin : g_first
      // for items outside the set, the upper part of the numerator is already below the divisor
      assign rem_in = MaxIterW'(num_i >> QuotW);
      assign lo_in  = num_i[QuotW-1:0];
      assign ctl_in = ctl_i;
      assign wr_in  = wr_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign ctl_in = ctl_q[s-1];
      assign wr_in  = wr_q[s-1];
    end

    assign trial = {rem_in, lo_in[QuotW-1]};
    assign diff  = trial - {1'b0, div_i};
    assign take  = trial >= {1'b0, div_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else if (en_i) begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? diff[MaxIterW-1:0] : trial[MaxIterW-1:0];
        lo_q[s]  <= {lo_in[QuotW-2:0], take};
        wr_q[s]  <= wr_in;
      end
    end
  end

  assign ctl_o  = ctl_q[QuotW-1];
  assign quot_o = lo_q[QuotW-1];
  assign wr_o   = wr_q[QuotW-1];

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[QuotW-1].valid && (ctl_q[QuotW-1].action == ACT_LOOKUP) &&
    !ctl_q[QuotW-1].in_set |-> rem_q[QuotW-1] < div_i)
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/pli_blend.sv =====
// ----------------------------------------------------------------------------
// pli_blend
// linear blend of two palette colors by a fixed-point fraction
// ----------------------------------------------------------------------------
module pli_blend #(
  parameter int unsigned FracBits = 8
) (
  input  pli_pkg::color_t      lo_i,
  input  pli_pkg::color_t      hi_i,
  input  logic [FracBits-1:0]  frac_i,
  output pli_pkg::color_t      color_o
);
  import pli_pkg::*;

  localparam int unsigned WtW  = FracBits + 1;
  localparam int unsigned SumW = ChanW + FracBits + 2;

  logic [WtW-1:0] w_hi;
  logic [WtW-1:0] w_lo;

  assign w_hi = WtW'(frac_i);
  assign w_lo = (WtW'(1) << FracBits) - w_hi;

  function automatic logic [ChanW-1:0] mix(input logic [ChanW-1:0] a,
                                           input logic [ChanW-1:0] b,
                                           input logic [WtW-1:0]   wa,
                                           input logic [WtW-1:0]   wb);
    logic [SumW-1:0] acc;
    acc = SumW'(a) * SumW'(wa) + SumW'(b) * SumW'(wb);
    return acc[FracBits +: ChanW];
  endfunction

  assign color_o.red   = mix(lo_i.red,   hi_i.red,   w_lo, w_hi);
  assign color_o.green = mix(lo_i.green, hi_i.green, w_lo, w_hi);
  assign color_o.blue  = mix(lo_i.blue,  hi_i.blue,  w_lo, w_hi);
  assign color_o.alpha = mix(lo_i.alpha, hi_i.alpha, w_lo, w_hi);

endmodule
